// ===== hw/rtl/frc_pkg.sv =====
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types, constants and helper functions for the frame rewrapper:
// microcode word layout, program entry points, command lookup and CRC step.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

  // Frame marks and CRC polynomial (CRC-16/XMODEM, init zero, no reflection).
  localparam logic [7:0]  HEAD_MARK = 8'hAA;
  localparam logic [7:0]  TAIL_MARK = 8'h55;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // Command codes picked from the source frame length.
  localparam logic [15:0] CMD_NONE = 16'h0000;
  localparam logic [15:0] CMD_11   = 16'hFF11;
  localparam logic [15:0] CMD_21   = 16'hFF21;
  localparam logic [15:0] CMD_31   = 16'hFF31;
  localparam logic [15:0] CMD_33   = 16'hFF33;
  localparam logic [15:0] CMD_34   = 16'hFF34;
  localparam logic [15:0] CMD_35   = 16'hFF35;

  // Microprogram layout: 34 header steps, one payload step, three trailer steps.
  localparam int unsigned HEADER_BYTES = 34;
  localparam int unsigned PROG_LEN     = HEADER_BYTES + 4;
  localparam int unsigned PC_W         = $clog2(PROG_LEN);

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_HEADER   = pc_t'(0);
  localparam pc_t PC_ADDR_LO  = pc_t'(1);
  localparam pc_t PC_ADDR_HI  = pc_t'(8);
  localparam pc_t PC_GAP0_LO  = pc_t'(9);
  localparam pc_t PC_GAP0_HI  = pc_t'(24);
  localparam pc_t PC_CMD_HI   = pc_t'(25);
  localparam pc_t PC_CMD_LO   = pc_t'(26);
  localparam pc_t PC_GAP1_LO  = pc_t'(27);
  localparam pc_t PC_GAP1_HI  = pc_t'(32);
  localparam pc_t PC_LEN      = pc_t'(33);
  localparam pc_t PC_DATA     = pc_t'(HEADER_BYTES);
  localparam pc_t PC_CRC_HI   = pc_t'(HEADER_BYTES + 1);
  localparam pc_t PC_CRC_LO   = pc_t'(HEADER_BYTES + 2);
  localparam pc_t PC_TAIL     = pc_t'(HEADER_BYTES + 3);

  // Byte source selected by a control word.
  localparam logic [3:0] SRC_ZERO   = 4'd0;
  localparam logic [3:0] SRC_HEAD   = 4'd1;
  localparam logic [3:0] SRC_ADDR   = 4'd2;
  localparam logic [3:0] SRC_CMD_HI = 4'd3;
  localparam logic [3:0] SRC_CMD_LO = 4'd4;
  localparam logic [3:0] SRC_LEN    = 4'd5;
  localparam logic [3:0] SRC_DATA   = 4'd6;
  localparam logic [3:0] SRC_CRC_HI = 4'd7;
  localparam logic [3:0] SRC_CRC_LO = 4'd8;
  localparam logic [3:0] SRC_TAIL   = 4'd9;

  // Sequencing after a step.
  localparam logic [1:0] JMP_NEXT            = 2'd0;
  localparam logic [1:0] JMP_END_IF_NOT_LAST = 2'd1;
  localparam logic [1:0] JMP_END             = 2'd2;

  typedef struct packed {
    logic [3:0] src;     // byte source
    logic [2:0] arg;     // address byte index, most significant first
    logic       crc_en;  // fold the emitted byte into the running CRC
    logic [1:0] jmp;     // sequencing
  } ucode_t;

  // Control store, one word per step.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = '{src: SRC_ZERO, arg: 3'd0, crc_en: 1'b1, jmp: JMP_NEXT};
    unique case (pc) inside
      PC_HEADER:                 w.src = SRC_HEAD;
      [PC_ADDR_LO:PC_ADDR_HI]: begin
        w.src = SRC_ADDR;
        w.arg = 3'(pc - PC_ADDR_LO);
      end
      [PC_GAP0_LO:PC_GAP0_HI],
      [PC_GAP1_LO:PC_GAP1_HI]:   w.src = SRC_ZERO;
      PC_CMD_HI:                 w.src = SRC_CMD_HI;
      PC_CMD_LO:                 w.src = SRC_CMD_LO;
      PC_LEN:                    w.src = SRC_LEN;
      PC_DATA: begin
        w.src = SRC_DATA;
        w.jmp = JMP_END_IF_NOT_LAST;
      end
      PC_CRC_HI: begin
        w.src    = SRC_CRC_HI;
        w.crc_en = 1'b0;
      end
      PC_CRC_LO: begin
        w.src    = SRC_CRC_LO;
        w.crc_en = 1'b0;
      end
      PC_TAIL: begin
        w.src    = SRC_TAIL;
        w.crc_en = 1'b0;
        w.jmp    = JMP_END;
      end
      default: begin
        w.crc_en = 1'b0;
        w.jmp    = JMP_END;
      end
    endcase
    return w;
  endfunction

  // Command code for a source length; zero marks an unsupported length.
  function automatic logic [15:0] command_for(input logic [7:0] len);
    logic [15:0] cmd;
    case (len) inside
      8'd5:         cmd = CMD_11;
      8'd29, 8'd34: cmd = CMD_21;
      8'd10, 8'd15: cmd = CMD_31;
      8'd53, 8'd58: cmd = CMD_33;
      8'd20, 8'd25: cmd = CMD_34;
      8'd30, 8'd35: cmd = CMD_35;
      default:      cmd = CMD_NONE;
    endcase
    return cmd;
  endfunction

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/frc_ifs.sv =====
// ----------------------------------------------------------------------------
// frc_ifs
// Valid/ready channels of the frame rewrapper: source bytes in, outer frame
// bytes out, and the concentrator address write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] frame_length;

  modport source (output valid, output data_byte, output frame_length, input ready);
  modport sink   (input valid, input data_byte, input frame_length, output ready);
endinterface

interface frc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

interface frc_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] concentrator_address;

  modport source (output valid, output concentrator_address, input ready);
  modport sink   (input valid, input concentrator_address, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/frame_rewrap_with_crc16_core.sv =====
// ----------------------------------------------------------------------------
// frame_rewrap_with_crc16_core
// Wraps source frame bytes in an outer frame with header, CRC-16 and tail.
// ----------------------------------------------------------------------------
// Usage:
//   src carries one source byte per request together with the total source
//   length; the length is taken on the first byte of each frame. dst carries
//   the outer frame one byte per request: run_last marks the last byte caused
//   by one source byte, frame_end marks the 0x55 tail. cfg writes the 64-bit
//   concentrator address, which is always accepted; write it between frames.
//   Throughput: a microcoded sequencer emits one output byte per cycle while
//   dst is ready. The first byte of a supported frame produces the 34 header
//   bytes and the payload byte, a middle byte only the payload byte, and the
//   last byte the payload byte, CRC high, CRC low and tail. Bytes of a
//   frame with an unsupported length are taken at one per cycle and produce
//   nothing. Acceptance starts the sequencer, whose first step then loads the
//   output register. A single output register holds the current byte; when
//   dst stalls, the sequencer waits. The next source byte is taken as soon as
//   the last byte of the current one sits in the output register.
//   Reset clears the frame state, the CRC and the address register.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rewrap_with_crc16_core (
  input  wire logic clk,
  input  wire logic rst,
  frc_in_if.sink    src,
  frc_out_if.source dst,
  frc_cfg_if.sink   cfg
);
  import frc_pkg::*;

  // Frame tracking and sequencer registers.
  logic [63:0] addr;
  logic [7:0]  bytes_seen;
  logic [7:0]  held_length;
  logic        length_supported;
  logic        busy;
  pc_t         pc;
  logic [7:0]  data_hold;
  logic        item_last;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        frame_end;
  logic        out_valid;

  logic        in_take;
  logic        first;
  logic [7:0]  cur_len;
  logic        cur_supported;
  logic        cur_last;
  logic        step;
  ucode_t      uw;
  logic [15:0] cmd;
  logic [15:0] crc;
  logic [7:0]  addr_byte;
  logic [7:0]  step_byte;
  logic        step_end;

  assign cfg.ready = 1'b1;
  assign src.ready = !busy;
  assign in_take   = src.valid && src.ready;

  // Frame accounting for the incoming byte.
  assign first         = (bytes_seen == 8'd0);
  assign cur_len       = first ? src.frame_length : held_length;
  assign cur_supported = first ? (command_for(src.frame_length) != CMD_NONE)
                               : length_supported;
  assign cur_last      = ({1'b0, bytes_seen} + 9'd1) >= {1'b0, cur_len};

  // Address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= 64'd0;
    end else if (cfg.valid && cfg.ready) begin
      addr <= cfg.concentrator_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen       <= 8'd0;
      held_length      <= 8'd0;
      length_supported <= 1'b0;
    end else if (in_take) begin
      if (first) begin
        held_length <= src.frame_length;
      end
      bytes_seen       <= cur_last ? 8'd0 : bytes_seen + 8'd1;
      length_supported <= cur_last ? 1'b0 : cur_supported;
    end
  end

  // Decode of the current step.
  assign step = busy && (!out_valid || dst.ready);
  assign uw   = ucode_rom(pc);
  assign cmd  = command_for(held_length);

  always_comb begin
    case (uw.arg)
      3'd0:    addr_byte = addr[63:56];
      3'd1:    addr_byte = addr[55:48];
      3'd2:    addr_byte = addr[47:40];
      3'd3:    addr_byte = addr[39:32];
      3'd4:    addr_byte = addr[31:24];
      3'd5:    addr_byte = addr[23:16];
      3'd6:    addr_byte = addr[15:8];
      default: addr_byte = addr[7:0];
    endcase
  end

  always_comb begin
    unique case (uw.src)
      SRC_ZERO:   step_byte = 8'h00;
      SRC_HEAD:   step_byte = HEAD_MARK;
      SRC_ADDR:   step_byte = addr_byte;
      SRC_CMD_HI: step_byte = cmd[15:8];
      SRC_CMD_LO: step_byte = cmd[7:0];
      SRC_LEN:    step_byte = held_length;
      SRC_DATA:   step_byte = data_hold;
      SRC_CRC_HI: step_byte = crc[15:8];
      SRC_CRC_LO: step_byte = crc[7:0];
      SRC_TAIL:   step_byte = TAIL_MARK;
      default:    step_byte = 8'h00;
    endcase
  end

  assign step_end = (uw.jmp == JMP_END) || ((uw.jmp == JMP_END_IF_NOT_LAST) && !item_last);

  // Running CRC, cleared as the header starts.
  frc_crc16_acc u_crc (
    .clk    (clk),
    .rst    (rst),
    .clear  (in_take && cur_supported && first),
    .update (step && uw.crc_en),
    .data   (step_byte),
    .crc    (crc)
  );

  // Sequencer: entry on a supported byte, one step per free output slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_HEADER;
    end else if (in_take && cur_supported) begin
      busy <= 1'b1;
      pc   <= first ? PC_HEADER : PC_DATA;
    end else if (step) begin
      busy <= !step_end;
      pc   <= pc + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      data_hold <= src.data_byte;
      item_last <= cur_last;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte  <= step_byte;
      run_last  <= step_end;
      frame_end <= (uw.src == SRC_TAIL);
    end
  end

  assign dst.valid     = out_valid;
  assign dst.out_byte  = out_byte;
  assign dst.run_last  = run_last;
  assign dst.frame_end = frame_end;

  // The tail closes both the frame and the burst of its source byte.
  a_tail_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last && (out_byte == TAIL_MARK))
    else $error("tail byte without run_last or with wrong value");

  // The program counter never leaves the program while busy.
  a_pc_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc <= PC_TAIL))
    else $error("sequencer ran past the end of the program");

  // A supported first byte starts the header program.
  a_header_entry: assert property (@(posedge clk) disable iff (rst)
    in_take && cur_supported && first |=> busy && (pc == PC_HEADER))
    else $error("header program not entered");

  // No byte is accepted while the sequencer is still working.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !(step && step_end) |=> !in_take)
    else $error("source byte accepted during sequence");

endmodule

`default_nettype wire

// ===== hw/rtl/frc_crc16_acc.sv =====
// ----------------------------------------------------------------------------
// frc_crc16_acc
// Running CRC-16/XMODEM register, folding in one byte per cycle while update is set.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_crc16_acc (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        clear,
  input  wire logic        update,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc
);
  import frc_pkg::*;

  logic [15:0] crc_next;

  // Clearing takes effect before the byte of the same cycle is folded in.
  always_comb begin
    crc_next = clear ? 16'h0000 : crc;
    if (update) begin
      crc_next = crc16_byte(crc_next, data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= 16'h0000;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

`default_nettype wire

// ===== bench/frame_rewrap_with_crc16_core_tb.sv =====
// ----------------------------------------------------------------------------
// frame_rewrap_with_crc16_core_tb
// Self-checking bench for the frame rewrapper. Source bytes go in through a
// valid/ready driver fed from a queue. Each accepted request is run through a
// local predictor that builds the outer frame: header, payload, CRC-16/XMODEM
// and tail. A monitor checks every output byte against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_rewrap_with_crc16_core_tb;
  import frc_pkg::*;

  localparam int unsigned QUIET_CYCLES = 40;
  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned PHASE_BYTES  = 5;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] length;
  } src_byte_t;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       frame_end;
  } outer_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  frc_in_if  in_ch();
  frc_out_if out_ch();
  frc_cfg_if cfg_ch();

  frame_rewrap_with_crc16_core DUT (
    .clk (clk),
    .rst (rst),
    .src (in_ch),
    .dst (out_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  // Source requests waiting to be offered, and outer frame bytes still due.
  src_byte_t   src_bytes_waiting[$];
  outer_byte_t outer_bytes_due[$];

  // Predictor state: position in the source frame, latched length, CRC,
  // whether the latched length has a command, and the address register.
  logic [7:0]  pos_in_frame = 8'd0;
  logic [7:0]  latched_len  = 8'd0;
  logic [15:0] crc_acc      = 16'd0;
  logic        len_ok       = 1'b0;
  logic [63:0] addr_shadow  = 64'd0;

  int unsigned items_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned bytes_dropped  = 0;
  int unsigned bytes_checked  = 0;
  int unsigned frames_seen    = 0;
  int unsigned address_writes = 0;
  int unsigned burst_len      = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  logic        steady         = 1'b0;

  // Random idle length: mostly none, sometimes a few cycles, rarely long.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Command code for a source length; CMD_NONE means the frame is dropped.
  function automatic logic [15:0] cmd_for_length(input logic [7:0] len);
    case (len)
      8'd5:          return CMD_11;
      8'd29, 8'd34:  return CMD_21;
      8'd10, 8'd15:  return CMD_31;
      8'd53, 8'd58:  return CMD_33;
      8'd20, 8'd25:  return CMD_34;
      8'd30, 8'd35:  return CMD_35;
      default:       return CMD_NONE;
    endcase
  endfunction

  // CRC-16/XMODEM, one input bit at a time, most significant bit first.
  function automatic logic [15:0] xmodem_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Append one predicted output byte, optionally folding it into the CRC.
  task automatic emit_outer(input logic [7:0] b, input logic fold, input logic tail);
    outer_byte_t ob;
    if (fold) begin
      crc_acc = xmodem_fold(crc_acc, b);
    end
    ob.value     = b;
    ob.run_last  = 1'b0;
    ob.frame_end = tail;
    outer_bytes_due.push_back(ob);
    burst_len++;
  endtask

  // Predict the outer frame bytes caused by one accepted source byte.
  task automatic rewrap_source_byte(input logic [7:0] data, input logic [7:0] len);
    logic [15:0] cmd;
    logic [15:0] crc_snap;
    logic        ends;
    outer_byte_t ob;
    burst_len = 0;
    if (pos_in_frame == 8'd0) begin
      latched_len = len;
      cmd         = cmd_for_length(len);
      len_ok      = (cmd != CMD_NONE);
      crc_acc     = 16'd0;
      if (len_ok) begin
        emit_outer(HEAD_MARK, 1'b1, 1'b0);
        for (int k = 7; k >= 0; k--) begin
          emit_outer(addr_shadow[8*k +: 8], 1'b1, 1'b0);
        end
        repeat (16) emit_outer(8'h00, 1'b1, 1'b0);
        emit_outer(cmd[15:8], 1'b1, 1'b0);
        emit_outer(cmd[7:0], 1'b1, 1'b0);
        // Three gap bytes, then the upper three bytes of the 32-bit length.
        repeat (6) emit_outer(8'h00, 1'b1, 1'b0);
        emit_outer(latched_len, 1'b1, 1'b0);
      end
    end
    ends = ({1'b0, pos_in_frame} + 9'd1) >= {1'b0, latched_len};
    if (len_ok) begin
      emit_outer(data, 1'b1, 1'b0);
      if (ends) begin
        crc_snap = crc_acc;
        emit_outer(crc_snap[15:8], 1'b0, 1'b0);
        emit_outer(crc_snap[7:0], 1'b0, 1'b0);
        emit_outer(TAIL_MARK, 1'b0, 1'b1);
      end
    end else begin
      bytes_dropped++;
    end
    if (ends) begin
      pos_in_frame = 8'd0;
      len_ok       = 1'b0;
      crc_acc      = 16'd0;
    end else begin
      pos_in_frame = pos_in_frame + 8'd1;
    end
    // The last byte caused by this request carries run_last.
    if (burst_len != 0) begin
      ob = outer_bytes_due.pop_back();
      ob.run_last = 1'b1;
      outer_bytes_due.push_back(ob);
    end
  endtask

  // Source side: offer queued requests, with random gaps between them.
  src_byte_t   pick;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rewrap_source_byte(in_ch.data_byte, in_ch.frame_length);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (src_bytes_waiting.size() != 0) begin
          pick = src_bytes_waiting.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.data_byte    <= pick.data;
          in_ch.frame_length <= pick.length;
          gap_left           <= steady ? 0 : idle_span();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output side ready: random stalls, plus long hold-offs so the block backs up.
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 150;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (bytes_checked >= next_hold_at && next_hold_at < 1000) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 700;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= idle_span();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check each accepted output byte against the oldest prediction.
  outer_byte_t due;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (outer_bytes_due.size() == 0) begin
        $error("unexpected output byte %02h with nothing predicted", out_ch.out_byte);
        fail_count++;
      end else begin
        due = outer_bytes_due.pop_front();
        if (out_ch.out_byte !== due.value) begin
          $error("out_byte mismatch: expected %02h, got %02h", due.value, out_ch.out_byte);
          fail_count++;
        end
        if (out_ch.run_last !== due.run_last) begin
          $error("run_last mismatch: expected %0b, got %0b", due.run_last, out_ch.run_last);
          fail_count++;
        end
        if (out_ch.frame_end !== due.frame_end) begin
          $error("frame_end mismatch: expected %0b, got %0b", due.frame_end,
                 out_ch.frame_end);
          fail_count++;
        end
      end
      bytes_checked <= bytes_checked + 1;
      if (out_ch.frame_end === 1'b1) begin
        frames_seen <= frames_seen + 1;
      end
    end
  end

  // Watchdog on a cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic queue_source_byte(input logic [7:0] data, input logic [7:0] len);
    src_byte_t sb;
    sb.data   = data;
    sb.length = len;
    src_bytes_waiting.push_back(sb);
    items_queued++;
  endtask

  // A whole source frame with random payload; now and then the length field
  // changes after the first byte, which the block must ignore.
  task automatic queue_frame(input logic [7:0] len);
    int unsigned count;
    count = (len == 8'd0) ? 1 : len;
    for (int unsigned k = 0; k < count; k++) begin
      if (k != 0 && $urandom_range(0, 4) == 0) begin
        queue_source_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        queue_source_byte(8'($urandom_range(0, 255)), len);
      end
    end
  endtask

  // Wait until every request is taken and every predicted byte has arrived,
  // then give the block time to finish any silent work.
  task automatic wait_until_quiet();
    while (bytes_accepted != items_queued || outer_bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Write the address register over its own channel; called at a clock edge.
  task automatic set_address(input logic [63:0] a);
    cfg_ch.concentrator_address <= a;
    cfg_ch.valid                <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    addr_shadow = a;
    address_writes++;
  endtask

  // Mostly short supported frames, some long ones, and unsupported noise.
  function automatic logic [7:0] pick_frame_length();
    logic [7:0] short_lens [5];
    logic [7:0] long_lens [6];
    logic [7:0] len;
    int unsigned r;
    short_lens = '{8'd5, 8'd10, 8'd15, 8'd20, 8'd25};
    long_lens  = '{8'd29, 8'd30, 8'd34, 8'd35, 8'd53, 8'd58};
    r = $urandom_range(0, 99);
    if (r < 62) begin
      return short_lens[$urandom_range(0, 4)];
    end else if (r < 80) begin
      return long_lens[$urandom_range(0, 5)];
    end else if (r < 85) begin
      return 8'd0;
    end
    do begin
      if ($urandom_range(0, 3) == 0) begin
        len = 8'($urandom_range(41, 64));
      end else begin
        len = 8'($urandom_range(1, 40));
      end
    end while (cmd_for_length(len) != CMD_NONE);
    return len;
  endfunction

  task automatic run_random_phase(input logic [63:0] addr);
    int unsigned counted;
    logic [7:0]  len;
    set_address(addr);
    counted = 0;
    while (counted < PHASE_BYTES) begin
      len = pick_frame_length();
      queue_frame(len);
      if (cmd_for_length(len) != CMD_NONE) begin
        counted += len;
      end
    end
    wait_until_quiet();
  endtask

  // Stimulus sequence.
  initial begin
    in_ch.valid                 = 1'b0;
    in_ch.data_byte             = 8'h00;
    in_ch.frame_length          = 8'h00;
    out_ch.ready                = 1'b0;
    cfg_ch.valid                = 1'b0;
    cfg_ch.concentrator_address = 64'd0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: all-ones address first.
    set_address(64'hFFFF_FFFF_FFFF_FFFF);
    // A zero length is a whole one-byte frame that produces nothing.
    queue_source_byte(8'hFF, 8'd0);
    // An unsupported length swallows its bytes silently.
    queue_source_byte(8'h00, 8'd2);
    queue_source_byte(8'h80, 8'd255);
    // A five-byte frame, split by an address write after its header went out.
    queue_source_byte(8'h00, 8'd5);
    queue_source_byte(8'hFF, 8'd5);
    wait_until_quiet();
    set_address(64'h0123_4567_89AB_CDEF);
    queue_source_byte(8'h5A, 8'd5);
    queue_source_byte(8'hA5, 8'd255);
    queue_source_byte(8'h01, 8'd0);
    // A ten-byte frame picks up the new address.
    for (int k = 0; k < 10; k++) begin
      queue_source_byte(8'(k * 8'h1B), 8'd10);
    end
    wait_until_quiet();

    // Random part over several address settings, one of them without idling.
    run_random_phase(64'd0);
    run_random_phase({$urandom, $urandom});
    steady = 1'b1;
    run_random_phase({$urandom, $urandom});
    steady = 1'b0;
    run_random_phase({1'b1, 31'($urandom), $urandom});

    if (outer_bytes_due.size() != 0) begin
      $error("%0d predicted output bytes never arrived", outer_bytes_due.size());
      fail_count++;
    end
    $display("Ran %0d source bytes (%0d dropped by unsupported lengths) under %0d addresses,",
             bytes_accepted, bytes_dropped, address_writes);
    $display("checking %0d output bytes across %0d outer frames.", bytes_checked,
             frames_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/frc_pkg.sv
hw/rtl/frc_ifs.sv
hw/rtl/frc_crc16_acc.sv
hw/rtl/frame_rewrap_with_crc16_core.sv
bench/frame_rewrap_with_crc16_core_tb.sv
